// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lfu_pkg.sv -----
package lfu_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NUM_W    = $clog2(CAPACITY + 1);
  localparam int CAP_W    = 5;
  localparam int LIM_W    = (NUM_W > CAP_W) ? NUM_W : CAP_W;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 16;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W-1:0] rank_t;

  typedef struct packed {
    logic                     func;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] value_out;
  } rsp_t;

  // One slot as seen through the store's read port.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    rank_t             rank;
  } entry_t;

  // Update request from the sequencer to the store.
  typedef struct packed {
    logic              touch;
    logic              evict;
    logic              insert;
    logic              wr_data;
    slot_t             slot;
    rank_t             rank;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } store_cmd_t;

  // What one pass over the slots has found.
  typedef struct packed {
    logic              hit;
    slot_t             hit_slot;
    rank_t             hit_rank;
    logic [DATA_W-1:0] hit_data;
    logic [CNT_W-1:0]  hit_count;
    logic [NUM_W-1:0]  num_valid;
    logic              free_found;
    slot_t             free_slot;
    logic              victim_found;
    slot_t             victim_slot;
    logic [CNT_W-1:0]  victim_count;
    rank_t             victim_rank;
  } scan_t;

endpackage

// ----- rtl/lfu_cache_policy.sv -----
// Each request runs through a scan of all CAPACITY slots, a decision state, up to two
// update states (evict then insert, or a touch) and an output load.
// The scan reads one slot per cycle through the store's single read port; a new
// request is not taken until the last result is loaded; no overlap of requests.
// Reset clears the sequencer, all slot valid bits and the output valid, and
// sets the capacity register to 16; slot contents are not cleared.
`include "assert_macros.svh"

module lfu_cache_policy (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  lfu_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lfu_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);
  import lfu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_EVICT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_TOUCH  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic                done, done_next;
  slot_t               idx;
  req_t                req_q;
  logic [CAP_W-1:0]    capacity;
  logic                evict_q;
  logic                accept;
  logic                load_rsp;
  logic [LIM_W-1:0]    cap_ext;
  logic [LIM_W-1:0]    cap_eff;
  logic                full;
  logic                put_miss_evict;
  slot_t               ins_slot;
  logic                last_slot;
  entry_t              rd_entry;
  scan_t               scan;
  store_cmd_t          cmd;
  logic [CAPACITY-1:0] valid_vec;
  logic [NUM_W-1:0]    held;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE) || done;
  assign load_rsp  = done && (!rsp_valid || !rsp_stall);
  assign last_slot = (idx == SLOT_W'(CAPACITY - 1));

  assign cap_ext = LIM_W'(capacity);
  assign cap_eff = (cap_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : cap_ext;
  assign full    = LIM_W'(scan.num_valid) >= cap_eff;

  assign put_miss_evict = (req_q.func == FUNC_PUT) && (cap_eff != '0) && !scan.hit && full;

  // After an eviction the new entry goes to the lowest free slot, which may
  // be the slot just vacated.
  assign ins_slot = (evict_q && (!scan.free_found || (scan.victim_slot < scan.free_slot))) ?
                    scan.victim_slot : scan.free_slot;

  always_comb begin
    state_next = state;
    done_next  = done;
    unique case (state)
      ST_IDLE: begin
        if (load_rsp) begin
          done_next = 1'b0;
        end else if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (req_q.func == FUNC_GET) begin
          state_next = scan.hit ? ST_TOUCH : ST_IDLE;
          done_next  = !scan.hit;
        end else if (cap_eff == '0) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end else if (scan.hit) begin
          state_next = ST_TOUCH;
        end else if (full) begin
          state_next = ST_EVICT;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_EVICT: begin
        state_next = ST_INSERT;
      end
      ST_INSERT, ST_TOUCH: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
        done_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (accept) begin
        idx <= '0;
      end else if (state == ST_SCAN) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (state == ST_DECIDE) begin
      evict_q <= put_miss_evict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.hit <= scan.hit;
      if (req_q.func == FUNC_GET) begin
        rsp.value_out <= scan.hit ? scan.hit_data : MISS_VALUE;
      end else begin
        rsp.value_out <= '0;
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.key  = req_q.key;
    cmd.data = req_q.value;
    unique case (state)
      ST_TOUCH: begin
        cmd.touch   = 1'b1;
        cmd.wr_data = (req_q.func == FUNC_PUT);
        cmd.slot    = scan.hit_slot;
        cmd.rank    = scan.hit_rank;
        cmd.count   = (scan.hit_count == COUNT_MAX) ? scan.hit_count :
                      scan.hit_count + 1'b1;
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        cmd.slot  = scan.victim_slot;
        cmd.rank  = scan.victim_rank;
      end
      ST_INSERT: begin
        cmd.insert = evict_q || scan.free_found;
        cmd.slot   = ins_slot;
        cmd.count  = CNT_W'(1);
      end
      ST_IDLE, ST_SCAN, ST_DECIDE: begin
        cmd.touch = 1'b0;
      end
      default: begin
        cmd.touch = 1'b0;
      end
    endcase
  end

  lfu_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (idx),
    .rd_entry  (rd_entry),
    .cmd       (cmd),
    .valid_vec (valid_vec)
  );

  lfu_scan u_scan (
    .clk   (clk),
    .clear (accept),
    .step  (state == ST_SCAN),
    .idx   (idx),
    .ent   (rd_entry),
    .key   (req_q.key),
    .res   (scan)
  );

  assign held = NUM_W'($countones(valid_vec));

  `ASSERT_NEXT(a_insert_adds_one, clk, rst, cmd.insert, held == $past(held) + 1'b1, "bad insert")
  `ASSERT_NEXT(a_evict_drops_one, clk, rst, cmd.evict, held + 1'b1 == $past(held), "no eviction")
  `ASSERT_NEXT(a_touch_keeps_set, clk, rst, cmd.touch, $stable(valid_vec), "valid set moved")
  `ASSERT_NOW(a_evict_has_victim, clk, rst, cmd.evict, scan.victim_found, "no victim")

endmodule

// ----- rtl/lfu_store.sv -----
module lfu_store (
  input  logic                          clk,
  input  logic                          rst,
  input  lfu_pkg::slot_t                rd_idx,
  output lfu_pkg::entry_t               rd_entry,
  input  lfu_pkg::store_cmd_t           cmd,
  output logic [lfu_pkg::CAPACITY-1:0]  valid_vec
);
  import lfu_pkg::*;

  logic [CAPACITY-1:0] valid;
  logic [KEY_W-1:0]    keys   [CAPACITY];
  logic [DATA_W-1:0]   datas  [CAPACITY];
  logic [CNT_W-1:0]    counts [CAPACITY];
  rank_t               ranks  [CAPACITY];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.evict) begin
      valid[cmd.slot] <= 1'b0;
    end else if (cmd.insert) begin
      valid[cmd.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      keys[cmd.slot] <= cmd.key;
    end
    if (cmd.insert || (cmd.touch && cmd.wr_data)) begin
      datas[cmd.slot] <= cmd.data;
    end
    if (cmd.insert || cmd.touch) begin
      counts[cmd.slot] <= cmd.count;
    end
  end

  // Every slot keeps its own recency rank and adjusts it against the
  // broadcast rank, so the ranks of the valid slots stay a dense 0..n-1.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.touch) begin
        if (SLOT_W'(i) == cmd.slot) begin
          ranks[i] <= '0;
        end else if (valid[i] && (ranks[i] < cmd.rank)) begin
          ranks[i] <= ranks[i] + 1'b1;
        end
      end else if (cmd.evict) begin
        if (valid[i] && (ranks[i] > cmd.rank)) begin
          ranks[i] <= ranks[i] - 1'b1;
        end
      end else if (cmd.insert) begin
        if (SLOT_W'(i) == cmd.slot) begin
          ranks[i] <= '0;
        end else if (valid[i]) begin
          ranks[i] <= ranks[i] + 1'b1;
        end
      end
    end
  end

  assign rd_entry.valid = valid[rd_idx];
  assign rd_entry.key   = keys[rd_idx];
  assign rd_entry.data  = datas[rd_idx];
  assign rd_entry.count = counts[rd_idx];
  assign rd_entry.rank  = ranks[rd_idx];
  assign valid_vec      = valid;

endmodule

// ----- rtl/lfu_scan.sv -----
module lfu_scan (
  input  logic                      clk,
  input  logic                      clear,
  input  logic                      step,
  input  lfu_pkg::slot_t            idx,
  input  lfu_pkg::entry_t           ent,
  input  logic [lfu_pkg::KEY_W-1:0] key,
  output lfu_pkg::scan_t            res
);
  import lfu_pkg::*;

  scan_t acc;
  scan_t acc_next;
  logic  match;
  logic  take_victim;

  // One slot per cycle: key match, free-slot search and the victim compare
  // (lowest count, then oldest rank) all share this single compare stage.
  always_comb begin
    match       = ent.valid && (ent.key == key);
    take_victim = ent.valid &&
                  (!acc.victim_found || (ent.count < acc.victim_count) ||
                   ((ent.count == acc.victim_count) && (ent.rank > acc.victim_rank)));
    acc_next = acc;
    if (match) begin
      acc_next.hit       = 1'b1;
      acc_next.hit_slot  = idx;
      acc_next.hit_rank  = ent.rank;
      acc_next.hit_data  = ent.data;
      acc_next.hit_count = ent.count;
    end
    if (ent.valid) begin
      acc_next.num_valid = acc.num_valid + 1'b1;
    end else if (!acc.free_found) begin
      acc_next.free_found = 1'b1;
      acc_next.free_slot  = idx;
    end
    if (take_victim) begin
      acc_next.victim_found = 1'b1;
      acc_next.victim_slot  = idx;
      acc_next.victim_count = ent.count;
      acc_next.victim_rank  = ent.rank;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (step) begin
      acc <= acc_next;
    end
  end

  assign res = acc;

endmodule

// ----- test/lfu_sb_pkg.sv -----
`timescale 1ns / 100ps

package lfu_sb_pkg;
  import lfu_pkg::*;

  class lfu_scoreboard;
    bit                slot_valid [CAPACITY];
    logic [KEY_W-1:0]  slot_key   [CAPACITY];
    logic [DATA_W-1:0] slot_data  [CAPACITY];
    int unsigned       slot_count [CAPACITY];
    int unsigned       slot_rank  [CAPACITY];
    logic [CAP_W-1:0]  capacity;
    rsp_t              expected_rsp [$];
    int                errors;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function int locate(logic [KEY_W-1:0] k);
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_valid[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    function int unsigned held();
      int unsigned n;
      n = 0;
      foreach (slot_valid[i]) if (slot_valid[i]) n++;
      return n;
    endfunction

    // Moves a slot to the front of the recency order and bumps its use count.
    function void touch(int s);
      int unsigned r;
      r = slot_rank[s];
      foreach (slot_valid[i]) begin
        if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[s] = 0;
      if (slot_count[s] < COUNT_MAX) slot_count[s]++;
    endfunction

    function void drop_victim();
      int victim;
      int unsigned r;
      victim = -1;
      foreach (slot_valid[i]) begin
        if (slot_valid[i]) begin
          if (victim < 0 || slot_count[i] < slot_count[victim] ||
              (slot_count[i] == slot_count[victim] &&
               slot_rank[i] > slot_rank[victim])) begin
            victim = i;
          end
        end
      end
      if (victim < 0) return;
      r = slot_rank[victim];
      slot_valid[victim] = 1'b0;
      foreach (slot_valid[i]) begin
        if (slot_valid[i] && slot_rank[i] > r) slot_rank[i]--;
      end
    endfunction

    function void place(logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
      int free;
      free = -1;
      for (int i = 0; i < CAPACITY; i++) begin
        if (!slot_valid[i]) begin
          free = i;
          break;
        end
      end
      if (free < 0) return;
      foreach (slot_valid[i]) if (slot_valid[i]) slot_rank[i]++;
      slot_valid[free] = 1'b1;
      slot_key[free]   = k;
      slot_data[free]  = v;
      slot_count[free] = 1;
      slot_rank[free]  = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t        res;
      int          s;
      int unsigned lim;
      s   = locate(r.key);
      lim = (capacity > CAPACITY) ? CAPACITY : capacity;
      res.hit       = (s >= 0);
      res.value_out = '0;
      if (r.func == FUNC_GET) begin
        if (s >= 0) begin
          touch(s);
          res.value_out = slot_data[s];
        end else begin
          res.value_out = MISS_VALUE;
        end
      end else if (lim != 0) begin
        if (s >= 0) begin
          slot_data[s] = r.value;
          touch(s);
        end else begin
          if (held() >= lim) drop_victim();
          place(r.key, r.value);
        end
      end
      expected_rsp.push_back(res);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("unexpected response: hit %0d value_out %h", got.hit, got.value_out);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.value_out !== want.value_out) begin
        $error("value_out: expected %h, got %h", want.value_out, got.value_out);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import lfu_pkg::*;
  import lfu_sb_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 2000000;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  bit               quiet;
  bit               hold_off;
  logic [KEY_W-1:0] key_pool [24];
  int               pool_size;
  lfu_scoreboard    sb;

  lfu_cache_policy u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.capacity = cfg_data;
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic req_t mk(logic f, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
    req_t r;
    r.func  = f;
    r.key   = k;
    r.value = v;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   c;
    c = $urandom_range(0, 99);
    r.func = ($urandom_range(0, 99) < 45) ? FUNC_PUT : FUNC_GET;
    if (c < 85) begin
      r.key = key_pool[$urandom_range(0, pool_size - 1)];
    end else if (c < 95) begin
      r.key = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       r.key = 32'h8000_0000;
        1:       r.key = 32'h7fff_ffff;
        2:       r.key = 32'h0000_0000;
        default: r.key = 32'hffff_ffff;
      endcase
    end
    r.value = $urandom;
    return r;
  endfunction

  // Receiver side: random stall stretches, plus one long hold-off on request.
  initial begin : rsp_side
    int n;
    rsp_stall <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (quiet) begin
        rsp_stall <= 1'b0;
        @(negedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 2) == 0);
        n = gap_len();
        repeat (n + 1) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue(input req_t item);
    int n;
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : main
    int phase;
    int sent;
    int n;
    sb = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Field extremes and both operations at the reset capacity.
    issue(mk(FUNC_GET, 32'h8000_0000, 32'h0000_0000));
    issue(mk(FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff));
    issue(mk(FUNC_GET, 32'h8000_0000, 32'hffff_ffff));
    issue(mk(FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000));
    issue(mk(FUNC_PUT, 32'h7fff_ffff, 32'h0000_0000));
    issue(mk(FUNC_GET, 32'h7fff_ffff, 32'h1234_5678));
    issue(mk(FUNC_PUT, 32'h0000_0000, 32'hffff_ffff));
    issue(mk(FUNC_PUT, 32'hffff_ffff, 32'h5555_5555));
    issue(mk(FUNC_GET, 32'hffff_ffff, 32'haaaa_aaaa));
    issue(mk(FUNC_GET, 32'haaaa_aaaa, 32'h0000_0000));

    // With no capacity, puts change nothing but gets still find entries.
    settle();
    write_capacity(5'd0);
    issue(mk(FUNC_PUT, 32'h0000_0005, 32'h0000_0055));
    issue(mk(FUNC_PUT, 32'h0000_0000, 32'h0000_0077));
    issue(mk(FUNC_GET, 32'h0000_0005, 32'h0000_0000));
    issue(mk(FUNC_GET, 32'h0000_0000, 32'h0000_0000));

    // Capacity below the number held: one eviction per new key.
    settle();
    write_capacity(5'd2);
    issue(mk(FUNC_PUT, 32'h0000_0009, 32'h0000_0099));
    issue(mk(FUNC_GET, 32'h8000_0000, 32'h0000_0000));
    issue(mk(FUNC_GET, 32'h0000_0009, 32'h0000_0000));
    issue(mk(FUNC_PUT, 32'h0000_0010, 32'hdead_beef));

    // Capacity above the slot count is clamped.
    settle();
    write_capacity(5'd31);
    issue(mk(FUNC_PUT, 32'h0000_0021, 32'h0000_0001));
    issue(mk(FUNC_PUT, 32'h0000_0022, 32'h0000_0002));
    issue(mk(FUNC_GET, 32'h0000_0021, 32'h0000_0000));

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       write_capacity(5'd0);
        1:       write_capacity(5'd1);
        2:       write_capacity(5'd16);
        3:       write_capacity(5'd31);
        default: write_capacity(CAP_W'($urandom_range(2, 15)));
      endcase
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
      quiet = (phase % 4 == 3);
      // The sender keeps offering while the receiver holds off.
      if (phase == 1) hold_off = 1'b1;
      n = $urandom_range(60, 180);
      repeat (n) begin
        issue(random_req());
        sent++;
      end
      phase++;
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- lfu_cache_policy.f -----
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_store.sv
rtl/lfu_scan.sv
rtl/lfu_cache_policy.sv
test/lfu_sb_pkg.sv
test/tb.sv
